// ===== sv/csmm_pkg.sv =====
// Shared types and constants for the contact slip margin block.
// No dependencies; every other file in sv/ but csmm_checker imports this package.
package csmm_pkg;

   localparam int FORCE_W    = 32;
   localparam int NORMAL_W   = 16;
   localparam int MU_W       = 16;
   localparam int MU_FRAC    = 12;
   localparam int NORM_EXTRA = 10;
   localparam int PROD_W     = FORCE_W + NORMAL_W;       // one f*n product
   localparam int DOT_W      = PROD_W + 1;               // sum of three, signed
   localparam int ADOT_W     = DOT_W - 1;                // |dot|
   localparam int NSQ_W      = 32;                       // |n|^2
   localparam int NUM_W      = ADOT_W + NORM_EXTRA;      // dividend
   localparam int NLEN_W     = 26;                       // floor(sqrt(nsq * 2^20))
   localparam int RAD_W      = 64;
   localparam int ROOT_W     = 32;
   localparam int ALLOW_W    = MU_W + FORCE_W - MU_FRAC; // mu*fn >> 12
   localparam int MARGIN_W   = ALLOW_W + 2;

   localparam logic [MU_W-1:0] MU_RESET = 16'd2048;

   typedef struct packed {
      logic [ADOT_W-1:0]  adot;
      logic [NSQ_W-1:0]   nsq;
      logic [FORCE_W-1:0] mag;
      logic               last;
   } entry_type;

endpackage

// ===== sv/csmm_front.sv =====
// Front end: accepts contacts, forms |f.n| and |n|^2 one axis per step.
// Depends on csmm_pkg; feeds csmm_queue.
module csmm_front (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   output logic                        req_stall,
   input  logic [csmm_pkg::FORCE_W-1:0]  req_force_x,
   input  logic [csmm_pkg::FORCE_W-1:0]  req_force_y,
   input  logic [csmm_pkg::FORCE_W-1:0]  req_force_z,
   input  logic [csmm_pkg::NORMAL_W-1:0] req_normal_x,
   input  logic [csmm_pkg::NORMAL_W-1:0] req_normal_y,
   input  logic [csmm_pkg::NORMAL_W-1:0] req_normal_z,
   input  logic [csmm_pkg::FORCE_W-1:0]  req_force_magnitude,
   input  logic                        req_last_contact,
   output logic                        push,
   output csmm_pkg::entry_type         push_entry,
   input  logic                        queue_full
);
   import csmm_pkg::*;

   localparam logic [1:0] STEP_PUSH = 2'd3;

   logic                    busy_ff, busy_in;
   logic [1:0]              step_ff, step_in;
   logic [3*FORCE_W-1:0]    f_ff, f_in;
   logic [3*NORMAL_W-1:0]   n_ff, n_in;
   logic [FORCE_W-1:0]      mag_ff, mag_in;
   logic                    last_ff, last_in;
   logic signed [DOT_W-1:0] dot_ff, dot_in;
   logic [NSQ_W-1:0]        nsq_ff, nsq_in;

   logic signed [FORCE_W-1:0]  f_sel;
   logic signed [NORMAL_W-1:0] n_sel;
   logic signed [PROD_W-1:0]   prod;
   logic signed [2*NORMAL_W-1:0] nprod;
   logic accept;

   assign accept    = req_valid && !busy_ff;
   assign req_stall = busy_ff;

   always_comb begin
      case (step_ff)
         2'd0: begin
            f_sel = f_ff[FORCE_W-1:0];
            n_sel = n_ff[NORMAL_W-1:0];
         end
         2'd1: begin
            f_sel = f_ff[2*FORCE_W-1:FORCE_W];
            n_sel = n_ff[2*NORMAL_W-1:NORMAL_W];
         end
         default: begin
            f_sel = f_ff[3*FORCE_W-1:2*FORCE_W];
            n_sel = n_ff[3*NORMAL_W-1:2*NORMAL_W];
         end
      endcase
   end

   assign prod  = f_sel * n_sel;
   assign nprod = n_sel * n_sel;

   assign push = busy_ff && (step_ff == STEP_PUSH) && !queue_full;
   assign push_entry.adot = dot_ff[DOT_W-1] ? ADOT_W'(-dot_ff) : ADOT_W'(dot_ff);
   assign push_entry.nsq  = nsq_ff;
   assign push_entry.mag  = mag_ff;
   assign push_entry.last = last_ff;

   always_comb begin
      busy_in = busy_ff;
      step_in = step_ff;
      f_in    = f_ff;
      n_in    = n_ff;
      mag_in  = mag_ff;
      last_in = last_ff;
      dot_in  = dot_ff;
      nsq_in  = nsq_ff;
      if (accept) begin
         busy_in = 1'b1;
         step_in = 2'd0;
         f_in    = {req_force_z, req_force_y, req_force_x};
         n_in    = {req_normal_z, req_normal_y, req_normal_x};
         mag_in  = req_force_magnitude;
         last_in = req_last_contact;
         dot_in  = '0;
         nsq_in  = '0;
      end else if (busy_ff && step_ff != STEP_PUSH) begin
         dot_in  = dot_ff + DOT_W'(prod);
         nsq_in  = nsq_ff + NSQ_W'($unsigned(nprod));
         step_in = step_ff + 2'd1;
      end else if (push) begin
         busy_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         step_ff <= 2'd0;
      end else begin
         busy_ff <= busy_in;
         step_ff <= step_in;
      end
      f_ff    <= f_in;
      n_ff    <= n_in;
      mag_ff  <= mag_in;
      last_ff <= last_in;
      dot_ff  <= dot_in;
      nsq_ff  <= nsq_in;
   end

endmodule

// ===== sv/csmm_queue.sv =====
// Two-entry queue between front and back ends.
// Depends on csmm_pkg for the entry type.
module csmm_queue (
   input  logic                clock,
   input  logic                reset,
   input  logic                push,
   input  csmm_pkg::entry_type push_entry,
   output logic                full,
   input  logic                pop,
   output logic                head_valid,
   output csmm_pkg::entry_type head
);
   import csmm_pkg::*;

   entry_type  slot_ff [2];
   logic       wr_ff, wr_in, rd_ff, rd_in;
   logic [1:0] cnt_ff, cnt_in;

   assign full       = (cnt_ff == 2'd2);
   assign head_valid = (cnt_ff != 2'd0);
   assign head       = slot_ff[rd_ff];

   always_comb begin
      wr_in  = wr_ff ^ push;
      rd_in  = rd_ff ^ pop;
      cnt_in = cnt_ff + {1'b0, push} - {1'b0, pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= 1'b0;
         rd_ff  <= 1'b0;
         cnt_ff <= 2'd0;
      end else begin
         wr_ff  <= wr_in;
         rd_ff  <= rd_in;
         cnt_ff <= cnt_in;
      end
      if (push) slot_ff[wr_ff] <= push_entry;
   end

endmodule

// ===== sv/csmm_isqrt.sv =====
// Iterative integer square root, two radicand bits per cycle.
// Depends on csmm_pkg for widths.
module csmm_isqrt (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        start,
   input  logic [csmm_pkg::RAD_W-1:0]  radicand,
   output logic                        done,
   output logic [csmm_pkg::ROOT_W-1:0] root
);
   import csmm_pkg::*;

   logic [RAD_W-1:0]    x_ff, x_in;
   logic [ROOT_W+1:0]   rem_ff, rem_in;
   logic [ROOT_W-1:0]   root_ff, root_in;
   logic [4:0]          cnt_ff, cnt_in;
   logic                run_ff, run_in, done_ff, done_in;
   logic [ROOT_W+3:0]   rem_sh, trial;

   assign rem_sh = {rem_ff, x_ff[RAD_W-1:RAD_W-2]};
   assign trial  = {2'b00, root_ff, 2'b01};
   assign done   = done_ff;
   assign root   = root_ff;

   always_comb begin
      x_in    = x_ff;
      rem_in  = rem_ff;
      root_in = root_ff;
      cnt_in  = cnt_ff;
      run_in  = run_ff;
      done_in = 1'b0;
      if (start) begin
         x_in    = radicand;
         rem_in  = '0;
         root_in = '0;
         cnt_in  = '0;
         run_in  = 1'b1;
      end else if (run_ff) begin
         x_in   = {x_ff[RAD_W-3:0], 2'b00};
         cnt_in = cnt_ff + 5'd1;
         if (rem_sh >= trial) begin
            rem_in  = (ROOT_W+2)'(rem_sh - trial);
            root_in = {root_ff[ROOT_W-2:0], 1'b1};
         end else begin
            rem_in  = (ROOT_W+2)'(rem_sh);
            root_in = {root_ff[ROOT_W-2:0], 1'b0};
         end
         if (cnt_ff == 5'd31) begin
            run_in  = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff  <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         run_ff  <= run_in;
         done_ff <= done_in;
      end
      x_ff    <= x_in;
      rem_ff  <= rem_in;
      root_ff <= root_in;
      cnt_ff  <= cnt_in;
   end

endmodule

// ===== sv/csmm_back.sv =====
// Back end: normal length, division, tangential force, margin and minimum.
// Depends on csmm_pkg and csmm_isqrt; pops entries from csmm_queue.
module csmm_back (
   input  logic                          clock,
   input  logic                          reset,
   input  logic [csmm_pkg::MU_W-1:0]     friction_coef,
   input  logic                          head_valid,
   input  csmm_pkg::entry_type           head,
   output logic                          pop,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic [csmm_pkg::FORCE_W-1:0]  rsp_min_margin,
   output logic                          rsp_degenerate_seen
);
   import csmm_pkg::*;

   localparam logic [3:0] S_IDLE      = 4'd0;
   localparam logic [3:0] S_NLEN_GO   = 4'd1;
   localparam logic [3:0] S_NLEN_WAIT = 4'd2;
   localparam logic [3:0] S_DIV       = 4'd3;
   localparam logic [3:0] S_MUL       = 4'd4;
   localparam logic [3:0] S_RAD       = 4'd5;
   localparam logic [3:0] S_FT_GO     = 4'd6;
   localparam logic [3:0] S_FT_WAIT   = 4'd7;
   localparam logic [3:0] S_MARGIN    = 4'd8;
   localparam logic [3:0] S_EMIT      = 4'd9;
   localparam int         DIV_CNT_W   = $clog2(NUM_W);

   logic [3:0]            state_ff, state_in;
   entry_type             ent_ff, ent_in;
   logic [NLEN_W-1:0]     nlen_ff, nlen_in;
   logic [NUM_W-1:0]      num_ff, num_in, q_ff, q_in;
   logic [NLEN_W-1:0]     rem_ff, rem_in;
   logic [DIV_CNT_W-1:0]  dcnt_ff, dcnt_in;
   logic [FORCE_W-1:0]    fn_ff, fn_in;
   logic [RAD_W-1:0]      msq_ff, msq_in, fnsq_ff, fnsq_in, rad_ff, rad_in;
   logic [ALLOW_W-1:0]    allow_ff, allow_in;
   logic [ROOT_W-1:0]     ft_ff, ft_in;
   logic [FORCE_W-1:0]    min_ff, min_in;
   logic                  first_ff, first_in, deg_ff, deg_in;
   logic                  ovalid_ff, ovalid_in, odeg_ff, odeg_in;
   logic [FORCE_W-1:0]    omin_ff, omin_in;

   logic                  sq_start, sq_done;
   logic [RAD_W-1:0]      sq_x;
   logic [ROOT_W-1:0]     sq_root;
   logic [NLEN_W:0]       rem_sh;
   logic                  qbit;
   logic [MU_W+FORCE_W-1:0] mu_prod;
   logic signed [MARGIN_W-1:0] margin;
   logic [FORCE_W-1:0]    margin_sat;
   logic                  out_free;

   csmm_isqrt u_isqrt (
      .clock    (clock),
      .reset    (reset),
      .start    (sq_start),
      .radicand (sq_x),
      .done     (sq_done),
      .root     (sq_root)
   );

   assign sq_start = (state_ff == S_NLEN_GO) || (state_ff == S_FT_GO);
   assign sq_x     = (state_ff == S_NLEN_GO)
                     ? {12'd0, ent_ff.nsq, 20'd0} : rad_ff;
   assign pop      = (state_ff == S_IDLE) && head_valid;
   assign out_free = !ovalid_ff || !rsp_stall;

   assign rem_sh  = {rem_ff, num_ff[NUM_W-1]};
   assign qbit    = (rem_sh >= {1'b0, nlen_ff});
   assign q_in    = {q_ff[NUM_W-2:0], qbit};
   assign mu_prod = friction_coef * fn_ff;
   assign margin  = $signed({2'b00, allow_ff}) - $signed(MARGIN_W'(ft_ff));

   always_comb begin
      if (!margin[MARGIN_W-1] && (|margin[MARGIN_W-2:FORCE_W-1]))
         margin_sat = {1'b0, {(FORCE_W-1){1'b1}}};
      else if (margin[MARGIN_W-1] && !(&margin[MARGIN_W-2:FORCE_W-1]))
         margin_sat = {1'b1, {(FORCE_W-1){1'b0}}};
      else
         margin_sat = margin[FORCE_W-1:0];
   end

   always_comb begin
      state_in  = state_ff;
      ent_in    = ent_ff;
      nlen_in   = nlen_ff;
      num_in    = num_ff;
      rem_in    = rem_ff;
      dcnt_in   = dcnt_ff;
      fn_in     = fn_ff;
      msq_in    = msq_ff;
      fnsq_in   = fnsq_ff;
      rad_in    = rad_ff;
      allow_in  = allow_ff;
      ft_in     = ft_ff;
      min_in    = min_ff;
      first_in  = first_ff;
      deg_in    = deg_ff;
      ovalid_in = ovalid_ff && rsp_stall;
      omin_in   = omin_ff;
      odeg_in   = odeg_ff;
      case (state_ff)
         S_IDLE: begin
            if (head_valid) begin
               ent_in = head;
               if (head.nsq == '0) begin
                  fn_in    = '0;
                  deg_in   = 1'b1;
                  state_in = S_MUL;
               end else begin
                  state_in = S_NLEN_GO;
               end
            end
         end
         S_NLEN_GO: state_in = S_NLEN_WAIT;
         S_NLEN_WAIT: begin
            if (sq_done) begin
               nlen_in  = sq_root[NLEN_W-1:0];
               num_in   = {ent_ff.adot, {NORM_EXTRA{1'b0}}};
               rem_in   = '0;
               dcnt_in  = '0;
               state_in = S_DIV;
            end
         end
         S_DIV: begin
            rem_in  = qbit ? NLEN_W'(rem_sh - {1'b0, nlen_ff}) : rem_sh[NLEN_W-1:0];
            num_in  = {num_ff[NUM_W-2:0], 1'b0};
            dcnt_in = dcnt_ff + 1'b1;
            if (dcnt_ff == DIV_CNT_W'(NUM_W - 1)) begin
               fn_in    = (|q_in[NUM_W-1:FORCE_W]) ? '1 : q_in[FORCE_W-1:0];
               state_in = S_MUL;
            end
         end
         S_MUL: begin
            msq_in   = ent_ff.mag * ent_ff.mag;
            fnsq_in  = fn_ff * fn_ff;
            allow_in = mu_prod[MU_W+FORCE_W-1:MU_FRAC];
            state_in = S_RAD;
         end
         S_RAD: begin
            rad_in   = (msq_ff > fnsq_ff) ? msq_ff - fnsq_ff : '0;
            state_in = S_FT_GO;
         end
         S_FT_GO: state_in = S_FT_WAIT;
         S_FT_WAIT: begin
            if (sq_done) begin
               ft_in    = sq_root;
               state_in = S_MARGIN;
            end
         end
         S_MARGIN: begin
            if (first_ff || ($signed(margin_sat) < $signed(min_ff)))
               min_in = margin_sat;
            first_in = 1'b0;
            state_in = ent_ff.last ? S_EMIT : S_IDLE;
         end
         S_EMIT: begin
            if (out_free) begin
               ovalid_in = 1'b1;
               omin_in   = min_ff;
               odeg_in   = deg_ff;
               min_in    = '0;
               first_in  = 1'b1;
               deg_in    = 1'b0;
               state_in  = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   // the divider's quotient is only shifted while dividing
   always_ff @(posedge clock) begin
      if (state_ff == S_NLEN_WAIT) q_ff <= '0;
      else if (state_ff == S_DIV) q_ff <= q_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= S_IDLE;
         min_ff    <= '0;
         first_ff  <= 1'b1;
         deg_ff    <= 1'b0;
         ovalid_ff <= 1'b0;
      end else begin
         state_ff  <= state_in;
         min_ff    <= min_in;
         first_ff  <= first_in;
         deg_ff    <= deg_in;
         ovalid_ff <= ovalid_in;
      end
      ent_ff   <= ent_in;
      nlen_ff  <= nlen_in;
      num_ff   <= num_in;
      rem_ff   <= rem_in;
      dcnt_ff  <= dcnt_in;
      fn_ff    <= fn_in;
      msq_ff   <= msq_in;
      fnsq_ff  <= fnsq_in;
      rad_ff   <= rad_in;
      allow_ff <= allow_in;
      ft_ff    <= ft_in;
      omin_ff  <= omin_in;
      odeg_ff  <= odeg_in;
   end

   assign rsp_valid           = ovalid_ff;
   assign rsp_min_margin      = omin_ff;
   assign rsp_degenerate_seen = odeg_ff;

endmodule

// ===== sv/contact_slip_margin_min.sv =====
// Friction-cone slip margin per contact and its minimum over a grasp.
// Depends on csmm_pkg, csmm_front, csmm_queue, csmm_back (and csmm_isqrt).
//
// Each item is one contact. The block forms the normal force
// fn = |f.n| / |n| and the tangential force ft = sqrt(max(m^2 - fn^2, 0)),
// then the margin mu*fn - ft, saturated to signed 32 bits, and keeps the
// lowest margin of the grasp. On the contact flagged last one item leaves
// on rsp_ with that minimum and a flag telling whether any contact had a
// zero normal (such a contact counts with fn = 0). Forces share one
// fixed-point format; mu is unsigned Q4.12 from the csr_ port (reset 0.5);
// the user must write it only while the block is idle, and the block
// itself does not enforce this; csr_ready is always high. The front end
// takes a new contact only after pushing the last one into a two-entry
// queue, and waits while that queue is full; the back end sets the pace
// and works on one contact at a time: two 32-iteration square roots on one
// shared iterative unit, a one-bit-per-cycle divide of a 58-bit dividend,
// and steps for pop, multiply and bookkeeping, plus the output handoff on
// the last contact of a grasp. A contact with a zero normal skips the first
// root and the divide. A stalled result holds the back end in its emit step.
module contact_slip_margin_min (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_stall,
   input  logic signed [31:0]            req_force_x,
   input  logic signed [31:0]            req_force_y,
   input  logic signed [31:0]            req_force_z,
   input  logic signed [15:0]            req_normal_x,
   input  logic signed [15:0]            req_normal_y,
   input  logic signed [15:0]            req_normal_z,
   input  logic [31:0]                   req_force_magnitude,
   input  logic                          req_last_contact,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic signed [31:0]            rsp_min_margin,
   output logic                          rsp_degenerate_seen,
   input  logic                          csr_valid,
   output logic                          csr_ready,
   input  logic [15:0]                   csr_friction_coef
);
   import csmm_pkg::*;

   logic [MU_W-1:0] mu_ff, mu_in;
   logic            push, queue_full, pop, head_valid;
   entry_type       push_entry, head;
   logic [FORCE_W-1:0] min_margin;

   assign csr_ready = 1'b1;
   assign mu_in     = (csr_valid && csr_ready) ? csr_friction_coef : mu_ff;

   always_ff @(posedge clock) begin
      if (reset) mu_ff <= MU_RESET;
      else       mu_ff <= mu_in;
   end

   // front: accept and reduce the vectors to |f.n| and |n|^2
   csmm_front u_front (
      .clock               (clock),
      .reset               (reset),
      .req_valid           (req_valid),
      .req_stall           (req_stall),
      .req_force_x         (req_force_x),
      .req_force_y         (req_force_y),
      .req_force_z         (req_force_z),
      .req_normal_x        (req_normal_x),
      .req_normal_y        (req_normal_y),
      .req_normal_z        (req_normal_z),
      .req_force_magnitude (req_force_magnitude),
      .req_last_contact    (req_last_contact),
      .push                (push),
      .push_entry          (push_entry),
      .queue_full          (queue_full)
   );

   csmm_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_entry (push_entry),
      .full       (queue_full),
      .pop        (pop),
      .head_valid (head_valid),
      .head       (head)
   );

   // back: root, divide, margin, running minimum and output register
   csmm_back u_back (
      .clock               (clock),
      .reset               (reset),
      .friction_coef       (mu_ff),
      .head_valid          (head_valid),
      .head                (head),
      .pop                 (pop),
      .rsp_valid           (rsp_valid),
      .rsp_stall           (rsp_stall),
      .rsp_min_margin      (min_margin),
      .rsp_degenerate_seen (rsp_degenerate_seen)
   );

   assign rsp_min_margin = $signed(min_margin);

endmodule

// ===== sv/csmm_checker.sv =====
// Port-level checks for contact_slip_margin_min, bound to the top level.
// Depends only on the top level's ports.
module csmm_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_valid,
   input logic        req_stall,
   input logic        rsp_valid,
   input logic        rsp_stall,
   input logic [31:0] rsp_min_margin,
   input logic        rsp_degenerate_seen,
   input logic        csr_valid,
   input logic        csr_ready
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid)
      else $error("result dropped while stalled");

   a_rsp_stable: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> $stable(rsp_min_margin) && $stable(rsp_degenerate_seen))
      else $error("stalled result changed");

   a_reset_quiet: assert property (@(posedge clock)
      reset |=> !rsp_valid && !req_stall)
      else $error("block not idle after reset");

   a_csr_ready: assert property (@(posedge clock) disable iff (reset)
      csr_valid |-> csr_ready)
      else $error("register write refused");

endmodule

bind contact_slip_margin_min csmm_checker u_csmm_checker (
   .clock               (clock),
   .reset               (reset),
   .req_valid           (req_valid),
   .req_stall           (req_stall),
   .rsp_valid           (rsp_valid),
   .rsp_stall           (rsp_stall),
   .rsp_min_margin      (rsp_min_margin),
   .rsp_degenerate_seen (rsp_degenerate_seen),
   .csr_valid           (csr_valid),
   .csr_ready           (csr_ready)
);
